>>> sv/seven_segment_text_scanner_macros.svh
// Assertion helpers used by the seven-segment text scanner datapath.
`ifndef SEVEN_SEGMENT_TEXT_SCANNER_MACROS_SVH
`define SEVEN_SEGMENT_TEXT_SCANNER_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define SSTS_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("scanner invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define SSTS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanner implication violated");

// The consequent holds in the cycle after the antecedent.
`define SSTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanner next-cycle check violated");

`endif

>>> sv/ssts_pkg.sv
package ssts_pkg;

  localparam int DIGITS_W    = 4;
  localparam int UNITS_W     = 3;
  localparam int CFG_DATA_W  = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int CMD_W       = 2;
  localparam int CHAR_W      = 8;
  localparam int SEG_W       = 8;
  localparam int SEL_W       = 8;

  localparam logic [DIGITS_W-1:0] DIGITS_RESET = 4'd4;
  localparam logic [UNITS_W-1:0]  UNITS_RESET  = 3'd1;

  localparam logic [CFG_INDEX_W-1:0] REG_DIGITS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_UNITS  = 1'b1;

  localparam logic [SEG_W-1:0] SEG_DARK = 8'h00;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_BLANK  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic store_write;
    logic length_clear;
    logic scan_init;
    logic blank_init;
    logic mem_read;
    logic emit_scan;
    logic emit_blank;
    logic step_unit;
    logic step_blank;
    logic pos_advance;
    logic pos_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic length_zero;
    logic can_append;
    logic out_free;
    logic last_unit;
    logic last_blank;
  } dp_stat_t;

  // Character to segment pattern; anything not in the font shows dark.
  function automatic logic [SEG_W-1:0] seg_code(input logic [CHAR_W-1:0] ch);
    logic [SEG_W-1:0] seg;
    unique case (ch)
      8'h20:   seg = 8'h00;
      8'h30:   seg = 8'h3F;
      8'h31:   seg = 8'h06;
      8'h32:   seg = 8'h5B;
      8'h33:   seg = 8'h4F;
      8'h34:   seg = 8'h66;
      8'h35:   seg = 8'h6D;
      8'h36:   seg = 8'h7D;
      8'h37:   seg = 8'h07;
      8'h38:   seg = 8'h7F;
      8'h39:   seg = 8'h6F;
      8'h41:   seg = 8'h77;
      8'h43:   seg = 8'h39;
      8'h45:   seg = 8'h79;
      8'h46:   seg = 8'h71;
      8'h48:   seg = 8'h76;
      8'h4C:   seg = 8'h38;
      8'h50:   seg = 8'h73;
      8'h52:   seg = 8'h31;
      8'h55:   seg = 8'h3E;
      default: seg = SEG_DARK;
    endcase
    return seg;
  endfunction

endpackage

>>> sv/ssts_ctrl.sv
module ssts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  ssts_pkg::cmd_t     command,
  input  ssts_pkg::dp_stat_t stat,
  output ssts_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_BLANK = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (command)
            ssts_pkg::CMD_START: begin
              cmd.length_clear = 1'b1;
            end
            ssts_pkg::CMD_APPEND: begin
              cmd.store_write = stat.can_append;
            end
            ssts_pkg::CMD_TICK: begin
              // An empty message produces nothing and leaves the scan where it is.
              if (!stat.length_zero) begin
                cmd.scan_init = 1'b1;
                state_next    = ST_FETCH;
              end
            end
            ssts_pkg::CMD_BLANK: begin
              cmd.length_clear = 1'b1;
              cmd.blank_init   = 1'b1;
              state_next       = ST_BLANK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        cmd.mem_read = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_scan = 1'b1;
          if (stat.last_unit) begin
            cmd.pos_advance = 1'b1;
            state_next      = ST_IDLE;
          end else begin
            cmd.step_unit = 1'b1;
            state_next    = ST_FETCH;
          end
        end
      end
      ST_BLANK: begin
        if (stat.out_free) begin
          cmd.emit_blank = 1'b1;
          if (stat.last_blank) begin
            cmd.pos_clear = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            cmd.step_blank = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/ssts_dp.sv
`include "seven_segment_text_scanner_macros.svh"

module ssts_dp #(
  parameter int MAX_DIGITS = 8,
  parameter int MAX_UNITS  = 4,
  parameter int TEXT_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ssts_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ssts_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [ssts_pkg::CHAR_W-1:0]         character,
  input  ssts_pkg::dp_cmd_t                   cmd,
  output ssts_pkg::dp_stat_t                  stat,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ssts_pkg::SEG_W+ssts_pkg::SEL_W-1:0] m_tdata,
  output logic                                m_tlast
);

  localparam int DW = $clog2(MAX_DIGITS + 1);
  localparam int UW = $clog2(MAX_UNITS + 1);
  localparam int FW = $clog2(MAX_DIGITS * MAX_UNITS + 1);
  localparam int LW = $clog2(TEXT_DEPTH + 1);
  localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int PW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int JW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;

  // Configuration registers.
  logic [ssts_pkg::DIGITS_W-1:0] digits_reg;
  logic [ssts_pkg::UNITS_W-1:0]  units_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      digits_reg <= ssts_pkg::DIGITS_RESET;
      units_reg  <= ssts_pkg::UNITS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ssts_pkg::REG_DIGITS: digits_reg <= cfg_data[ssts_pkg::DIGITS_W-1:0];
        ssts_pkg::REG_UNITS:  units_reg  <= cfg_data[ssts_pkg::UNITS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register values saturated into their legal ranges.
  logic [DW-1:0] d_eff;
  logic [UW-1:0] u_eff;
  logic [FW-1:0] full;

  always_comb begin
    if (digits_reg == '0) begin
      d_eff = DW'(1);
    end else if (digits_reg > MAX_DIGITS) begin
      d_eff = DW'(MAX_DIGITS);
    end else begin
      d_eff = DW'(digits_reg);
    end
    if (units_reg == '0) begin
      u_eff = UW'(1);
    end else if (units_reg > MAX_UNITS) begin
      u_eff = UW'(MAX_UNITS);
    end else begin
      u_eff = UW'(units_reg);
    end
  end

  assign full = FW'(d_eff) * FW'(u_eff);

  // Message store and length.
  logic [ssts_pkg::CHAR_W-1:0] text_store [TEXT_DEPTH];
  logic [ssts_pkg::CHAR_W-1:0] mem_q;
  logic [LW-1:0]               length;
  logic [FW-1:0]               pad;
  logic [FW-1:0]               k_reg;
  logic [FW-1:0]               store_off;
  logic [AW-1:0]               rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (cmd.length_clear) begin
      length <= '0;
    end else if (cmd.store_write) begin
      length <= length + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_write) begin
      text_store[length[AW-1:0]] <= character;
    end
    if (cmd.mem_read) begin
      mem_q <= text_store[rd_addr];
    end
  end

  // Right justification: the first pad positions of the display are blank.
  always_comb begin
    if (length >= full) begin
      pad = '0;
    end else begin
      pad = full - FW'(length);
    end
  end

  // Its value only matters when k_reg is at or past the pad, so the wrap below is harmless.
  assign store_off = k_reg - pad;
  assign rd_addr   = AW'(store_off);

  // Scan position and per-tick counters.
  logic [PW-1:0] scan_pos;
  logic [PW-1:0] cur_pos;
  logic [JW-1:0] unit_idx;
  logic [PW-1:0] start_pos;
  logic          pos_last;
  logic          unit_last;

  assign start_pos = (DW'(scan_pos) >= d_eff) ? '0 : scan_pos;
  assign pos_last  = (DW'(cur_pos) + DW'(1)) == d_eff;
  assign unit_last = (UW'(unit_idx) + UW'(1)) == u_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pos <= '0;
    end else if (cmd.pos_clear) begin
      scan_pos <= '0;
    end else if (cmd.pos_advance) begin
      scan_pos <= pos_last ? '0 : cur_pos + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cur_pos  <= start_pos;
      unit_idx <= '0;
      k_reg    <= FW'(start_pos);
    end else if (cmd.blank_init) begin
      cur_pos  <= '0;
      unit_idx <= '0;
    end else if (cmd.step_unit) begin
      unit_idx <= unit_idx + JW'(1);
      k_reg    <= k_reg + FW'(d_eff);
    end else if (cmd.step_blank) begin
      if (unit_last) begin
        unit_idx <= '0;
        cur_pos  <= cur_pos + PW'(1);
      end else begin
        unit_idx <= unit_idx + JW'(1);
      end
    end
  end

  // Output register.
  logic                       out_valid;
  logic [ssts_pkg::SEG_W-1:0] out_seg;
  logic [ssts_pkg::SEL_W-1:0] out_sel;
  logic                       out_last;
  logic                       out_free;
  logic                       load;

  assign out_free = !out_valid || m_tready;
  assign load     = cmd.emit_scan || cmd.emit_blank;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_sel <= ssts_pkg::SEL_W'(1) << cur_pos;
      if (cmd.emit_scan && (k_reg >= pad)) begin
        out_seg <= ssts_pkg::seg_code(mem_q);
      end else begin
        out_seg <= ssts_pkg::SEG_DARK;
      end
      if (cmd.emit_scan) begin
        out_last <= unit_last;
      end else begin
        out_last <= unit_last && pos_last;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_sel, out_seg};
  assign m_tlast  = out_last;

  always_comb begin
    stat.length_zero = (length == '0);
    stat.can_append  = (length < full) && (length < TEXT_DEPTH);
    stat.out_free    = out_free;
    stat.last_unit   = unit_last;
    stat.last_blank  = unit_last && pos_last;
  end

  `SSTS_ASSERT_ALWAYS(a_length_bound, clk, rst, length <= TEXT_DEPTH)
  `SSTS_ASSERT_IMPLY(a_sel_onehot, clk, rst, out_valid, $onehot(out_sel))
  `SSTS_ASSERT_IMPLY(a_load_free, clk, rst, load, out_free)
  `SSTS_ASSERT_NEXT(a_clear_empties, clk, rst, cmd.length_clear, length == '0)

endmodule

>>> sv/seven_segment_text_scanner.sv
// Seven-segment text scanner: holds a message of up to digits_per_unit * unit_count
// characters (capped at TEXT_DEPTH), shown right-justified on a multiplexed display.
// Commands arrive on the slave stream with the command code in s_tuser and the
// character in s_tdata; result words (segments, digit select, tlast on the final
// word of a command) leave on the master stream. Start and append produce nothing.
// In a scan tick, each unit's character needs one read of the single-port message
// store and one load of the output register. Blank all makes one output register
// load per word. One command is handled at a time; the message store has no reset
// and only entries below the current length are ever shown. Configuration register
// 0 is digits_per_unit, register 1 is unit_count; write them only while idle.
module seven_segment_text_scanner #(
  parameter int MAX_DIGITS = 8,
  parameter int MAX_UNITS  = 4,
  parameter int TEXT_DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [ssts_pkg::CFG_INDEX_W-1:0]           cfg_index,
  input  logic [ssts_pkg::CFG_DATA_W-1:0]            cfg_data,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  input  logic [ssts_pkg::CHAR_W-1:0]                s_tdata,  // [7:0] character
  input  logic [ssts_pkg::CMD_W-1:0]                 s_tuser,  // [1:0] command
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // [7:0] segments, [15:8] digit_select
  output logic [ssts_pkg::SEG_W+ssts_pkg::SEL_W-1:0] m_tdata,
  output logic                                       m_tlast
);

  ssts_pkg::dp_cmd_t  cmd;
  ssts_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  ssts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .command  (ssts_pkg::cmd_t'(s_tuser)),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssts_dp #(
    .MAX_DIGITS (MAX_DIGITS),
    .MAX_UNITS  (MAX_UNITS),
    .TEXT_DEPTH (TEXT_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .character (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

>>> bench/ssts_display_checker.sv
`timescale 1ns / 100ps

module ssts_display_checker #(
  parameter int MAX_DIGITS = 8,
  parameter int MAX_UNITS  = 4,
  parameter int TEXT_DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_valid,
  input  logic                                       cfg_ready,
  input  logic [ssts_pkg::CFG_INDEX_W-1:0]           cfg_index,
  input  logic [ssts_pkg::CFG_DATA_W-1:0]            cfg_data,
  input  logic                                       s_tvalid,
  input  logic                                       s_tready,
  input  logic [ssts_pkg::CHAR_W-1:0]                s_tdata,  // [7:0] character
  input  logic [ssts_pkg::CMD_W-1:0]                 s_tuser,  // [1:0] command
  input  logic                                       m_tvalid,
  input  logic                                       m_tready,
  // [7:0] segments, [15:8] digit_select
  input  logic [ssts_pkg::SEG_W+ssts_pkg::SEL_W-1:0] m_tdata,
  input  logic                                       m_tlast,
  output int                                         fail_count,
  output int                                         outstanding,
  output int                                         words_checked
);

  localparam int SEG_W = ssts_pkg::SEG_W;
  localparam int SEL_W = ssts_pkg::SEL_W;

  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic [SEL_W-1:0] digit_select;
    logic             last;
  } scan_word_t;

  logic [ssts_pkg::DIGITS_W-1:0] digits_reg;
  logic [ssts_pkg::UNITS_W-1:0]  units_reg;
  logic [ssts_pkg::CHAR_W-1:0]   text_mem [TEXT_DEPTH];
  int                            text_len;
  int                            scan_pos;
  scan_word_t                    display_words[$];

  function automatic logic [SEG_W-1:0] glyph_pattern(logic [ssts_pkg::CHAR_W-1:0] ch);
    logic [SEG_W-1:0] pattern;
    case (ch)
      " ":     pattern = 8'h00;
      "0":     pattern = 8'h3F;
      "1":     pattern = 8'h06;
      "2":     pattern = 8'h5B;
      "3":     pattern = 8'h4F;
      "4":     pattern = 8'h66;
      "5":     pattern = 8'h6D;
      "6":     pattern = 8'h7D;
      "7":     pattern = 8'h07;
      "8":     pattern = 8'h7F;
      "9":     pattern = 8'h6F;
      "A":     pattern = 8'h77;
      "C":     pattern = 8'h39;
      "E":     pattern = 8'h79;
      "F":     pattern = 8'h71;
      "H":     pattern = 8'h76;
      "L":     pattern = 8'h38;
      "P":     pattern = 8'h73;
      "R":     pattern = 8'h31;
      "U":     pattern = 8'h3E;
      default: pattern = ssts_pkg::SEG_DARK;
    endcase
    return pattern;
  endfunction

  // Updates the display state for one command and queues the words it shows.
  task automatic compute_display_words(ssts_pkg::cmd_t cmd, logic [ssts_pkg::CHAR_W-1:0] ch);
    int d, u, full, len, pad, k, j, p;
    scan_word_t w;
    d = (digits_reg == 0) ? 1 : (digits_reg > MAX_DIGITS) ? MAX_DIGITS : int'(digits_reg);
    u = (units_reg == 0) ? 1 : (units_reg > MAX_UNITS) ? MAX_UNITS : int'(units_reg);
    full = d * u;
    case (cmd)
      ssts_pkg::CMD_START: begin
        text_len = 0;
      end
      ssts_pkg::CMD_APPEND: begin
        if (text_len < full && text_len < TEXT_DEPTH) begin
          text_mem[text_len] = ch;
          text_len++;
        end
      end
      ssts_pkg::CMD_TICK: begin
        if (text_len != 0) begin
          // A position left over from a wider setting restarts the scan.
          if (scan_pos >= d) scan_pos = 0;
          len = (text_len < full) ? text_len : full;
          pad = full - len;
          for (j = 0; j < u; j++) begin
            k = scan_pos + j * d;
            w.segments = (k >= pad) ? glyph_pattern(text_mem[k - pad]) : ssts_pkg::SEG_DARK;
            w.digit_select = SEL_W'(1) << scan_pos;
            w.last = (j == u - 1);
            display_words.push_back(w);
          end
          scan_pos = (scan_pos + 1) % d;
        end
      end
      ssts_pkg::CMD_BLANK: begin
        text_len = 0;
        for (p = 0; p < d; p++) begin
          for (j = 0; j < u; j++) begin
            w.segments = ssts_pkg::SEG_DARK;
            w.digit_select = SEL_W'(1) << p;
            w.last = (p == d - 1) && (j == u - 1);
            display_words.push_back(w);
          end
        end
        scan_pos = 0;
      end
    endcase
  endtask

  always @(posedge clk) begin
    scan_word_t want;
    if (rst) begin
      digits_reg = ssts_pkg::DIGITS_RESET;
      units_reg = ssts_pkg::UNITS_RESET;
      text_len = 0;
      scan_pos = 0;
      display_words.delete();
    end else begin
      // Words leaving now belong to commands accepted at earlier edges.
      if (m_tvalid && m_tready) begin
        words_checked++;
        if (display_words.size() == 0) begin
          $error("unexpected word: segments %h, digit_select %h, last %b",
                 m_tdata[SEG_W-1:0], m_tdata[SEG_W+SEL_W-1:SEG_W], m_tlast);
          fail_count++;
        end else begin
          want = display_words.pop_front();
          if (m_tdata[SEG_W-1:0] !== want.segments) begin
            $error("segments: expected %h, got %h", want.segments, m_tdata[SEG_W-1:0]);
            fail_count++;
          end
          if (m_tdata[SEG_W+SEL_W-1:SEG_W] !== want.digit_select) begin
            $error("digit_select: expected %h, got %h", want.digit_select,
                   m_tdata[SEG_W+SEL_W-1:SEG_W]);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %b, got %b", want.last, m_tlast);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ssts_pkg::REG_DIGITS) digits_reg = cfg_data[ssts_pkg::DIGITS_W-1:0];
        else units_reg = cfg_data[ssts_pkg::UNITS_W-1:0];
      end
      if (s_tvalid && s_tready) compute_display_words(ssts_pkg::cmd_t'(s_tuser), s_tdata);
    end
    outstanding = display_words.size();
  end

endmodule

>>> bench/tb_seven_segment_text_scanner.sv
`timescale 1ns / 100ps

module tb_seven_segment_text_scanner;

  localparam int MAX_DIGITS    = 8;
  localparam int MAX_UNITS     = 4;
  localparam int TEXT_DEPTH    = 32;
  localparam int LONG_STALL    = 300;
  localparam int SETTLE_CYCLES = 48;
  localparam int PHASE_ITEMS   = 38;
  localparam int PHASE_COUNT   = 8;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                                       clk;
  logic                                       rst;
  logic                                       cfg_valid;
  logic                                       cfg_ready;
  logic [ssts_pkg::CFG_INDEX_W-1:0]           cfg_index;
  logic [ssts_pkg::CFG_DATA_W-1:0]            cfg_data;
  logic                                       s_tvalid;
  logic                                       s_tready;
  logic [ssts_pkg::CHAR_W-1:0]                s_tdata;
  logic [ssts_pkg::CMD_W-1:0]                 s_tuser;
  logic                                       m_tvalid;
  logic                                       m_tready;
  logic [ssts_pkg::SEG_W+ssts_pkg::SEL_W-1:0] m_tdata;
  logic                                       m_tlast;

  int         fail_count;
  int         outstanding;
  int         words_checked;
  idle_mode_t idle_mode = IDLE_NONE;
  int         stall_requests = 0;
  int         stalls_served = 0;
  int         commands_sent = 0;
  int         settings_used = 0;
  int         display_digits;
  int         display_cap;
  int         phase;
  string      glyphs = " 0123456789ACEFHLPRU";

  seven_segment_text_scanner #(
    .MAX_DIGITS(MAX_DIGITS),
    .MAX_UNITS (MAX_UNITS),
    .TEXT_DEPTH(TEXT_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  ssts_display_checker #(
    .MAX_DIGITS(MAX_DIGITS),
    .MAX_UNITS (MAX_UNITS),
    .TEXT_DEPTH(TEXT_DEPTH)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .words_checked(words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb_seven_segment_text_scanner: FAIL");
    $finish;
  end

  // Output side: random stalls per phase, plus a long hold-off on request.
  initial begin
    int hold;
    int stall_pct;
    m_tready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      stall_pct = (idle_mode == IDLE_RECEIVER) ? 67 : (idle_mode == IDLE_BOTH) ? 19 : 0;
      if (stalls_served != stall_requests) begin
        stalls_served++;
        hold = LONG_STALL;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_command(ssts_pkg::cmd_t cmd, logic [ssts_pkg::CHAR_W-1:0] ch);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 67 : (idle_mode == IDLE_BOTH) ? 19 : 0;
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= ch;
    do @(posedge clk); while (!s_tready);
    commands_sent++;
  endtask

  // Commands without words may still be in flight, so allow settling time.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [ssts_pkg::CFG_INDEX_W-1:0] idx,
                                logic [ssts_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [ssts_pkg::CFG_DATA_W-1:0] digits_data,
                           logic [ssts_pkg::CFG_DATA_W-1:0] units_data);
    int units;
    write_register(ssts_pkg::REG_DIGITS, digits_data);
    write_register(ssts_pkg::REG_UNITS, units_data);
    display_digits = (digits_data == 0) ? 1 :
                     (digits_data > MAX_DIGITS) ? MAX_DIGITS : int'(digits_data);
    units = (units_data[ssts_pkg::UNITS_W-1:0] == 0) ? 1 :
            (units_data[ssts_pkg::UNITS_W-1:0] > MAX_UNITS) ? MAX_UNITS :
            int'(units_data[ssts_pkg::UNITS_W-1:0]);
    display_cap = display_digits * units;
    settings_used++;
  endtask

  task automatic run_phase(int quota);
    int done, len, ticks, pick, i;
    done = 0;
    // The old message is scanned first under the new setting.
    repeat (3) begin
      send_command(ssts_pkg::CMD_TICK, 8'($urandom));
      done++;
    end
    while (done < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_command(ssts_pkg::CMD_START, 8'($urandom));
        done++;
        case ($urandom_range(0, 9))
          0:       len = display_cap + $urandom_range(1, 3);
          1:       len = display_cap;
          default: len = $urandom_range(1, (display_cap < 6) ? display_cap : 6);
        endcase
        for (i = 0; i < len; i++) begin
          send_command(ssts_pkg::CMD_APPEND, ($urandom_range(0, 3) != 0) ?
                       glyphs[$urandom_range(0, glyphs.len() - 1)] : 8'($urandom));
          if (i < display_cap) done++;
        end
        ticks = $urandom_range(1, 2 * display_digits + 1);
        repeat (ticks) begin
          send_command(ssts_pkg::CMD_TICK, 8'($urandom));
          done++;
        end
      end else if (pick < 77) begin
        send_command(ssts_pkg::CMD_BLANK, 8'($urandom));
        done++;
      end else if (pick < 87) begin
        send_command(ssts_pkg::CMD_TICK, 8'($urandom));
        done++;
      end else begin
        send_command(ssts_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    display_digits = ssts_pkg::DIGITS_RESET;
    display_cap = ssts_pkg::DIGITS_RESET * ssts_pkg::UNITS_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset setting of four digits on one unit.
    send_command(ssts_pkg::CMD_TICK, 8'hFF);     // empty text: no words, position stays
    send_command(ssts_pkg::CMD_BLANK, 8'h00);
    send_command(ssts_pkg::CMD_START, 8'h5A);
    send_command(ssts_pkg::CMD_APPEND, 8'h00);   // a zero character is stored and shows dark
    send_command(ssts_pkg::CMD_APPEND, "8");
    send_command(ssts_pkg::CMD_APPEND, 8'hFF);
    send_command(ssts_pkg::CMD_APPEND, " ");
    send_command(ssts_pkg::CMD_APPEND, "U");     // past the display width, so dropped
    repeat (5) send_command(ssts_pkg::CMD_TICK, 8'h00);
    send_command(ssts_pkg::CMD_START, 8'h00);
    send_command(ssts_pkg::CMD_APPEND, "E");     // a short message is right-justified
    repeat (3) send_command(ssts_pkg::CMD_TICK, 8'hA5);
    send_command(ssts_pkg::CMD_BLANK, 8'hFF);
    send_command(ssts_pkg::CMD_TICK, 8'h00);
    send_command(ssts_pkg::CMD_APPEND, "7");
    send_command(ssts_pkg::CMD_APPEND, "Z");
    send_command(ssts_pkg::CMD_TICK, 8'h00);
    drain();

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      idle_mode = idle_mode_t'(phase % 4);
      case (phase)
        0:       configure(4'd8, 4'd4);
        1:       configure(4'd1, 4'd1);
        2:       configure(4'd0, 4'd0);
        3:       configure(4'd15, 4'd15);
        4:       configure(4'd5, 4'd3);
        5:       configure(4'($urandom), 4'($urandom));
        6:       configure(4'd2, 4'd12);
        default: configure(4'd8, 4'd4);
      endcase
      // Hold the output off long enough for the input to back up.
      if (phase == 4) stall_requests++;
      run_phase(PHASE_ITEMS);
      drain();
    end

    $display("Sent %0d commands over %0d register settings with idle and stall phases.",
             commands_sent, settings_used);
    $display("Checked %0d display words; %0d mismatches found.", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("tb_seven_segment_text_scanner: PASS");
    end else begin
      $display("tb_seven_segment_text_scanner: FAIL");
    end
    $finish;
  end

endmodule
